FILE: sv/sbo_pkg.sv
// Shared types and constants for the superpixel border overlay.
// No dependencies; every other file of the block imports this package.
package sbo_pkg;

  // Fixed field widths of the stream and configuration payloads
  localparam int LabelFieldW = 16;
  localparam int ColorW      = 8;
  localparam int CfgW        = 11;

  // Color driven on a border pixel
  localparam logic [ColorW-1:0] ColorBorder = 8'd255;

  // Item command codes
  typedef enum logic {
    CmdPixel = 1'b0,
    CmdDrain = 1'b1
  } sbo_cmd_e;

  // Per-item neighbor qualifiers handed from control to the border stage
  typedef struct packed {
    logic is_pixel;   // item is a pixel, so the lower neighbor exists
    logic has_up;     // upper neighbor exists
    logic has_left;   // left neighbor exists
    logic has_right;  // right neighbor exists
    logic done;       // final pixel of the frame
  } sbo_ctl_t;

endpackage

FILE: sv/sbo_if.sv
// Stream interfaces of the superpixel border overlay: pixel input and result output.
// Depends on sbo_pkg for the payload widths.
interface sbo_pix_if import sbo_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [LabelFieldW-1:0] label;
  logic [ColorW-1:0]      red_in;
  logic [ColorW-1:0]      green_in;
  logic [ColorW-1:0]      blue_in;

  modport source (output valid, command, label, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, command, label, red_in, green_in, blue_in, output ready);
endinterface

interface sbo_res_if import sbo_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] red_out;
  logic [ColorW-1:0] green_out;
  logic [ColorW-1:0] blue_out;
  logic              on_border;
  logic              frame_done;

  modport source (output valid, red_out, green_out, blue_out, on_border, frame_done,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, on_border, frame_done,
                  output ready);
endinterface

FILE: sv/sbo_ctrl.sv
// Position control of the border overlay: width register, column, row and drain counters.
// Decodes each input transaction into line-store accesses; depends on sbo_pkg, sbo_pix_if.
module sbo_ctrl import sbo_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int LABEL_BITS = 16,
  localparam int PosW      = $clog2(MAX_WIDTH),
  localparam int EntryW    = LABEL_BITS + 3 * ColorW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CfgW-1:0]   cfg_wdata_i,
  sbo_pix_if.sink           pix_i,
  input  logic              take_i,
  output logic              load_o,
  output sbo_ctl_t          ctl_o,
  output logic [PosW-1:0]   pos_o,
  output logic              pend_we_o,
  output logic [EntryW-1:0] pend_wdata_o,
  output logic [LABEL_BITS-1:0] lower_label_o
);

  localparam int WidthW     = PosW + 1;
  localparam int CmpW       = (WidthW > CfgW) ? WidthW : CfgW;
  localparam int ResetWidth = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  logic [WidthW-1:0] width_q;
  logic [PosW-1:0]   col_q, col_d;
  logic [PosW-1:0]   drain_q, drain_d;
  logic [1:0]        rows_q, rows_d;

  logic              accept;
  logic              is_drain;
  logic              drain_act;
  logic              pix_act;
  logic [WidthW-1:0] pos_inc;
  logic              last;
  logic [LABEL_BITS-1:0] lab;

  // Hold the effective width, clamped to one and to MAX_WIDTH
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthW'(ResetWidth);
    end else if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        width_q <= WidthW'(1);
      end else if (CmpW'(cfg_wdata_i) > CmpW'(MAX_WIDTH)) begin
        width_q <= WidthW'(MAX_WIDTH);
      end else begin
        width_q <= WidthW'(cfg_wdata_i);
      end
    end
  end

  assign pix_i.ready = take_i;
  assign accept      = pix_i.valid && pix_i.ready;
  assign is_drain    = (sbo_cmd_e'(pix_i.command) == CmdDrain);

  // Drain needs a complete row and no partial one; pixels taken during a drain are dropped
  assign drain_act = (rows_q != 2'd0) && (col_q == '0);
  assign pix_act   = (drain_q == '0);

  assign pos_o   = is_drain ? drain_q : col_q;
  assign pos_inc = {1'b0, pos_o} + WidthW'(1);
  assign last    = (pos_inc >= width_q);
  assign lab     = LABEL_BITS'(pix_i.label);

  assign load_o = accept && (is_drain ? drain_act : (pix_act && (rows_q != 2'd0)));

  always_comb begin
    ctl_o.is_pixel  = !is_drain;
    ctl_o.has_up    = rows_q[1];
    ctl_o.has_left  = (pos_o != '0);
    ctl_o.has_right = !last;
    ctl_o.done      = is_drain && last;
  end

  assign pend_we_o     = accept && !is_drain && pix_act;
  assign pend_wdata_o  = {lab, pix_i.red_in, pix_i.green_in, pix_i.blue_in};
  assign lower_label_o = lab;

  // Advance column, row count and drain position per transaction
  always_comb begin
    col_d   = col_q;
    drain_d = drain_q;
    rows_d  = rows_q;
    if (accept) begin
      if (is_drain) begin
        if (drain_act) begin
          if (last) begin
            drain_d = '0;
            rows_d  = 2'd0;
            col_d   = '0;
          end else begin
            drain_d = pos_inc[PosW-1:0];
          end
        end
      end else if (pix_act) begin
        if (last) begin
          col_d = '0;
          if (rows_q != 2'd2) begin
            rows_d = rows_q + 2'd1;
          end
        end else begin
          col_d = pos_inc[PosW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      drain_q <= '0;
      rows_q  <= 2'd0;
    end else begin
      col_q   <= col_d;
      drain_q <= drain_d;
      rows_q  <= rows_d;
    end
  end

endmodule

FILE: sv/sbo_line_store.sv
// Line stores of the border overlay: pending row (label and color) and upper-row labels.
// Synchronous memories with registered reads; depends on sbo_pkg.
module sbo_line_store import sbo_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int LABEL_BITS = 16,
  localparam int PosW      = $clog2(MAX_WIDTH),
  localparam int EntryW    = LABEL_BITS + 3 * ColorW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [PosW-1:0]       pos_i,
  input  logic                  pend_we_i,
  input  logic [EntryW-1:0]     pend_wdata_i,
  input  logic                  upper_we_i,
  input  logic [PosW-1:0]       upper_waddr_i,
  output logic [EntryW-1:0]     cur_entry_o,
  output logic [LABEL_BITS-1:0] right_label_o,
  output logic [LABEL_BITS-1:0] upper_label_o
);

  localparam int Depth = 2 ** PosW;

  logic [EntryW-1:0]     pend_mem  [Depth];
  logic [LABEL_BITS-1:0] upper_mem [Depth];

  logic [PosW-1:0]       right_addr;
  logic [EntryW-1:0]     cur_q;
  logic [LABEL_BITS-1:0] right_q;
  logic [LABEL_BITS-1:0] upper_q;
  logic [LABEL_BITS-1:0] cur_label;
  logic                  fwd_hit_q;
  logic [LABEL_BITS-1:0] fwd_data_q;

  assign right_addr = pos_i + PosW'(1);
  assign cur_label  = cur_q[EntryW-1 -: LABEL_BITS];

  // Pending row: write new pixel, read current and right entries (read-first)
  always_ff @(posedge clk_i) begin
    if (pend_we_i) begin
      pend_mem[pos_i] <= pend_wdata_i;
    end
    if (rd_en_i) begin
      cur_q   <= pend_mem[pos_i];
      right_q <= pend_mem[right_addr][EntryW-1 -: LABEL_BITS];
    end
  end

  // Upper row: write the label of the emitted pixel at its position, read the entry above
  always_ff @(posedge clk_i) begin
    if (upper_we_i) begin
      upper_mem[upper_waddr_i] <= cur_label;
    end
    if (rd_en_i) begin
      upper_q    <= upper_mem[pos_i];
      fwd_data_q <= cur_label;
    end
  end

  // Forward a same-edge write to the entry being read (one-pixel rows)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_hit_q <= upper_we_i && (upper_waddr_i == pos_i);
    end
  end

  assign cur_entry_o   = cur_q;
  assign right_label_o = right_q;
  assign upper_label_o = fwd_hit_q ? fwd_data_q : upper_q;

endmodule

FILE: sv/sbo_border.sv
// Border decision stage and output register of the border overlay.
// Compares the pixel label with its neighbors; depends on sbo_pkg, sbo_res_if.
module sbo_border import sbo_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int LABEL_BITS = 16,
  localparam int PosW      = $clog2(MAX_WIDTH),
  localparam int EntryW    = LABEL_BITS + 3 * ColorW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  sbo_ctl_t              ctl_i,
  input  logic [PosW-1:0]       pos_i,
  input  logic [LABEL_BITS-1:0] lower_label_i,
  input  logic [EntryW-1:0]     cur_entry_i,
  input  logic [LABEL_BITS-1:0] right_label_i,
  input  logic [LABEL_BITS-1:0] upper_label_i,
  output logic                  take_o,
  output logic                  upper_we_o,
  output logic [PosW-1:0]       upper_waddr_o,
  sbo_res_if.source             res_o
);

  logic                  s1_valid_q;
  sbo_ctl_t              ctl_q;
  logic [PosW-1:0]       pos_q;
  logic [LABEL_BITS-1:0] lower_q;
  logic [LABEL_BITS-1:0] prev_q;
  logic                  out_valid_q;
  logic [ColorW-1:0]     red_q, green_q, blue_q;
  logic                  border_q, done_q;

  logic                  s1_move;
  logic [LABEL_BITS-1:0] cur_label;
  logic [ColorW-1:0]     cur_red, cur_green, cur_blue;
  logic                  border;

  assign cur_label = cur_entry_i[EntryW-1 -: LABEL_BITS];
  assign cur_red   = cur_entry_i[3*ColorW-1 -: ColorW];
  assign cur_green = cur_entry_i[2*ColorW-1 -: ColorW];
  assign cur_blue  = cur_entry_i[ColorW-1:0];

  // Advance when the output register is empty or being drained
  assign s1_move = s1_valid_q && (!out_valid_q || res_o.ready);
  assign take_o  = !s1_valid_q || s1_move;

  // Left neighbor is the label of the previously emitted pixel of this row
  assign border = (ctl_q.has_up    && (upper_label_i != cur_label)) ||
                  (ctl_q.has_left  && (prev_q        != cur_label)) ||
                  (ctl_q.has_right && (right_label_i != cur_label)) ||
                  (ctl_q.is_pixel  && (lower_q       != cur_label));

  assign upper_we_o    = s1_move && ctl_q.is_pixel;
  assign upper_waddr_o = pos_q;

  // Hold stage valid and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture item context and output payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ctl_q   <= ctl_i;
      pos_q   <= pos_i;
      lower_q <= lower_label_i;
    end
    if (s1_move) begin
      prev_q   <= cur_label;
      red_q    <= border ? ColorBorder : cur_red;
      green_q  <= border ? ColorBorder : cur_green;
      blue_q   <= border ? ColorBorder : cur_blue;
      border_q <= border;
      done_q   <= ctl_q.done;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.red_out    = red_q;
  assign res_o.green_out  = green_q;
  assign res_o.blue_out   = blue_q;
  assign res_o.on_border  = border_q;
  assign res_o.frame_done = done_q;

endmodule

FILE: sv/superpixel_border_overlay_top.sv
// Superpixel border overlay: marks 4-connected label boundaries white in a pixel stream.
// Instantiates sbo_ctrl, sbo_line_store and sbo_border; depends on sbo_pkg, sbo_if.
//
// Usage:
//   pix_i takes raster-order transactions. A pixel transaction (command 0) carries a
//   label and a color; it is emitted one row later, once its lower neighbor has arrived.
//   The first row of a frame gives no results. After the last row, send one drain
//   transaction (command 1) per pixel of that row; the last drained pixel has
//   frame_done set and the block is then ready for the next frame.
//   res_o delivers the recolored pixel with on_border and frame_done.
//   Write image_width through cfg_we_i/cfg_wdata_i only while the block is idle.
// Timing:
//   One transaction per cycle while res_o is not stalled. The line-store read and the
//   item context are registered when a transaction is loaded, and the border decision
//   is registered in the output register that drives res_o.valid.
//   The pending-row store is read at two addresses and written once per cycle; the
//   upper-row store is read and written once per cycle.
// Reset and stall:
//   Reset clears the counters and pipeline valids and loads image_width with 1024
//   (capped at MAX_WIDTH); the line stores need no clearing. When res_o stalls, the
//   output register holds, one more transaction is taken into the decision stage,
//   and pix_i.ready then drops until the output is taken.
module superpixel_border_overlay_top import sbo_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int LABEL_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  sbo_pix_if.sink         pix_i,
  sbo_res_if.source       res_o
);

  localparam int PosW   = $clog2(MAX_WIDTH);
  localparam int EntryW = LABEL_BITS + 3 * ColorW;

  logic                  take;
  logic                  load;
  sbo_ctl_t              ctl;
  logic [PosW-1:0]       pos;
  logic                  pend_we;
  logic [EntryW-1:0]     pend_wdata;
  logic [LABEL_BITS-1:0] lower_label;
  logic                  upper_we;
  logic [PosW-1:0]       upper_waddr;
  logic [EntryW-1:0]     cur_entry;
  logic [LABEL_BITS-1:0] right_label;
  logic [LABEL_BITS-1:0] upper_label;

  sbo_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .LABEL_BITS (LABEL_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pix_i         (pix_i),
    .take_i        (take),
    .load_o        (load),
    .ctl_o         (ctl),
    .pos_o         (pos),
    .pend_we_o     (pend_we),
    .pend_wdata_o  (pend_wdata),
    .lower_label_o (lower_label)
  );

  sbo_line_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .LABEL_BITS (LABEL_BITS)
  ) u_line_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_en_i       (load),
    .pos_i         (pos),
    .pend_we_i     (pend_we),
    .pend_wdata_i  (pend_wdata),
    .upper_we_i    (upper_we),
    .upper_waddr_i (upper_waddr),
    .cur_entry_o   (cur_entry),
    .right_label_o (right_label),
    .upper_label_o (upper_label)
  );

  sbo_border #(
    .MAX_WIDTH  (MAX_WIDTH),
    .LABEL_BITS (LABEL_BITS)
  ) u_border (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .ctl_i         (ctl),
    .pos_i         (pos),
    .lower_label_i (lower_label),
    .cur_entry_i   (cur_entry),
    .right_label_i (right_label),
    .upper_label_i (upper_label),
    .take_o        (take),
    .upper_we_o    (upper_we),
    .upper_waddr_o (upper_waddr),
    .res_o         (res_o)
  );

endmodule
